@@ rtl/core/tscf_pkg.sv @@
// Shared types and constants for the text section cleanup filter.
`default_nettype none

package tscf_pkg;

    localparam logic [7:0] NUL_BYTE   = 8'h00;
    localparam logic [7:0] MARK0_BYTE = 8'hEF;
    localparam logic [7:0] MARK1_BYTE = 8'hBB;
    localparam logic [7:0] MARK2_BYTE = 8'hBF;
    localparam logic [7:0] NEWLINE    = 8'h0A;
    localparam logic [7:0] DASH       = 8'h2D;

    // Number of held marker bytes
    localparam logic [1:0] HELD_NONE = 2'd0;
    localparam logic [1:0] HELD_EF   = 2'd1;
    localparam logic [1:0] HELD_EFBB = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    // Work for one input: separator, held flush, byte, trailing flush
    typedef struct packed {
        logic       sep;
        logic [1:0] pre_n;
        logic       byte_v;
        logic [7:0] data;
        logic [1:0] post_n;
    } cmd_t;

endpackage

`default_nettype wire

@@ rtl/core/text_section_cleanup_filter.sv @@
// Top level of the text section cleanup filter.
//
//  Channel | Direction | tdata          | tlast        | Meaning
//  s_      | in        | in_byte[7:0]   | section_last | raw section bytes
//  m_      | out       | out_byte[7:0]  | run_last     | cleaned bytes, separators
//
// One input beat per cycle while the command queue has room; the back end
// sends one beat per cycle while m_tready is high, so an item with one result
// sustains one per cycle. A separator takes SEPARATOR_DASHES + 3 beats;
// an item yields at most SEPARATOR_DASHES + 4. An input beat reaches m_ through
// the command queue, the back end's command register and its output register.
// Reset is synchronous on aresetn low and clears queue pointers and control state.
// A stall on m_ backs up into the queue and then drops s_tready.
`default_nettype none

module text_section_cleanup_filter #(
    parameter int SEPARATOR_DASHES = 21
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire  [7:0] s_tdata,   // in_byte[7:0]
    input  wire        s_tlast,   // section_last
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,   // out_byte[7:0]
    output logic       m_tlast    // run_last
);

    tscf_pkg::cmd_t push_cmd, head_cmd;
    logic           push, push_ready, pop, head_valid;

    tscf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_push   (push),
        .q_cmd    (push_cmd),
        .q_ready  (push_ready)
    );

    tscf_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .head_cmd   (head_cmd),
        .head_valid (head_valid)
    );

    tscf_back #(
        .SEPARATOR_DASHES (SEPARATOR_DASHES)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_cmd   (head_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

`default_nettype wire

@@ rtl/core/tscf_front.sv @@
// Front end: accepts bytes, tracks marker and null-run state, issues commands.
`default_nettype none

module tscf_front (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               s_tvalid,
    output logic              s_tready,
    input  wire  [7:0]        s_tdata,   // in_byte[7:0]
    input  wire               s_tlast,   // section_last
    output logic              q_push,
    output tscf_pkg::cmd_t    q_cmd,
    input  wire               q_ready
);

    logic [1:0] held_reg, held_next;
    logic       null_reg, null_next;
    logic       consumed;
    logic       accept;

    assign s_tready = q_ready;
    assign accept   = s_tvalid && q_ready;

    always_comb begin
        q_cmd        = '0;
        q_cmd.data   = s_tdata;
        held_next    = (held_reg == 2'd3) ? tscf_pkg::HELD_NONE : held_reg;
        null_next    = null_reg;
        consumed     = 1'b0;
        if (s_tdata == tscf_pkg::NUL_BYTE) begin
            q_cmd.pre_n = held_next;
            held_next   = tscf_pkg::HELD_NONE;
            null_next   = 1'b1;
        end else begin
            q_cmd.sep = null_reg;
            null_next = 1'b0;
            if (held_next == tscf_pkg::HELD_EF) begin
                if (s_tdata == tscf_pkg::MARK1_BYTE) begin
                    held_next = tscf_pkg::HELD_EFBB;
                    consumed  = 1'b1;
                end else begin
                    q_cmd.pre_n = tscf_pkg::HELD_EF;
                    held_next   = tscf_pkg::HELD_NONE;
                end
            end else if (held_next == tscf_pkg::HELD_EFBB) begin
                // Complete marker: drop it; a broken one flushes the held bytes
                if (s_tdata == tscf_pkg::MARK2_BYTE) begin
                    held_next = tscf_pkg::HELD_NONE;
                    consumed  = 1'b1;
                end else begin
                    q_cmd.pre_n = tscf_pkg::HELD_EFBB;
                    held_next   = tscf_pkg::HELD_NONE;
                end
            end
            if (!consumed) begin
                if (s_tdata == tscf_pkg::MARK0_BYTE) begin
                    held_next = tscf_pkg::HELD_EF;
                end else begin
                    q_cmd.byte_v = 1'b1;
                end
            end
        end
        if (s_tlast) begin
            q_cmd.post_n = held_next;
            held_next    = tscf_pkg::HELD_NONE;
            null_next    = 1'b0;
        end
    end

    // Skip commands that produce no beats
    assign q_push = accept && (q_cmd.sep || (q_cmd.pre_n != 2'd0) || q_cmd.byte_v
                               || (q_cmd.post_n != 2'd0));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            held_reg <= tscf_pkg::HELD_NONE;
            null_reg <= 1'b0;
        end else if (accept) begin
            held_reg <= held_next;
            null_reg <= null_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tscf_queue.sv @@
// Small command queue between front and back end.
`default_nettype none

module tscf_queue (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               push,
    input  tscf_pkg::cmd_t    push_cmd,
    output logic              push_ready,
    input  wire               pop,
    output tscf_pkg::cmd_t    head_cmd,
    output logic              head_valid
);

    tscf_pkg::cmd_t mem_reg [tscf_pkg::QUEUE_DEPTH];

    logic [tscf_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [tscf_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [tscf_pkg::QPTR_W:0]   count_reg, count_next;
    logic                        do_push, do_pop;

    assign push_ready = (count_reg != (tscf_pkg::QPTR_W+1)'(tscf_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/tscf_back.sv @@
// Back end: expands each command into output beats through an output register.
`default_nettype none

module tscf_back #(
    parameter int SEPARATOR_DASHES = 21
) (
    input  wire               aclk,
    input  wire               aresetn,
    input  wire               head_valid,
    input  tscf_pkg::cmd_t    head_cmd,
    output logic              pop,
    output logic              m_tvalid,
    input  wire               m_tready,
    output logic [7:0]        m_tdata,   // out_byte[7:0]
    output logic              m_tlast    // run_last
);

    localparam int SEP_LEN = SEPARATOR_DASHES + 3;
    localparam int CNT_W   = (SEP_LEN > 4) ? $clog2(SEP_LEN) : 2;

    typedef enum logic [4:0] {
        PH_IDLE = 5'b00001,
        PH_SEP  = 5'b00010,
        PH_PRE  = 5'b00100,
        PH_BYTE = 5'b01000,
        PH_POST = 5'b10000
    } phase_t;

    localparam logic [1:0] FROM_SEP  = 2'd0;
    localparam logic [1:0] FROM_PRE  = 2'd1;
    localparam logic [1:0] FROM_BYTE = 2'd2;
    localparam logic [1:0] FROM_POST = 2'd3;

    // First phase at or after the given one that has beats
    function automatic phase_t pick(tscf_pkg::cmd_t c, logic [1:0] from);
        phase_t p;
        p = PH_IDLE;
        if (from == FROM_SEP && c.sep) begin
            p = PH_SEP;
        end else if (from <= FROM_PRE && c.pre_n != 2'd0) begin
            p = PH_PRE;
        end else if (from <= FROM_BYTE && c.byte_v) begin
            p = PH_BYTE;
        end else if (c.post_n != 2'd0) begin
            p = PH_POST;
        end
        return p;
    endfunction

    phase_t         phase_reg, phase_next, after;
    tscf_pkg::cmd_t cur_reg, cur_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic           m_valid_reg, m_valid_next;
    logic [7:0]     m_data_reg, m_data_next;
    logic           m_last_reg, m_last_next;
    logic           busy, advance, phase_done, beat_last;
    logic [7:0]     beat_data;

    assign busy     = (phase_reg != PH_IDLE);
    assign advance  = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    always_comb begin
        beat_data  = tscf_pkg::NEWLINE;
        phase_done = 1'b0;
        after      = PH_IDLE;
        case (phase_reg)
            PH_SEP: begin
                if (cnt_reg != '0 && cnt_reg <= CNT_W'(SEPARATOR_DASHES)) begin
                    beat_data = tscf_pkg::DASH;
                end
                phase_done = (cnt_reg == CNT_W'(SEP_LEN - 1));
                after      = pick(cur_reg, FROM_PRE);
            end
            PH_PRE: begin
                beat_data  = (cnt_reg == '0) ? tscf_pkg::MARK0_BYTE : tscf_pkg::MARK1_BYTE;
                phase_done = (cnt_reg == CNT_W'(cur_reg.pre_n - 2'd1));
                after      = pick(cur_reg, FROM_BYTE);
            end
            PH_BYTE: begin
                beat_data  = cur_reg.data;
                phase_done = 1'b1;
                after      = pick(cur_reg, FROM_POST);
            end
            PH_POST: begin
                beat_data  = (cnt_reg == '0) ? tscf_pkg::MARK0_BYTE : tscf_pkg::MARK1_BYTE;
                phase_done = (cnt_reg == CNT_W'(cur_reg.post_n - 2'd1));
                after      = PH_IDLE;
            end
            default: begin
                beat_data  = tscf_pkg::NEWLINE;
                phase_done = 1'b0;
                after      = PH_IDLE;
            end
        endcase
        beat_last = phase_done && (after == PH_IDLE);
    end

    always_comb begin
        phase_next   = phase_reg;
        cur_next     = cur_reg;
        cnt_next     = cnt_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        pop          = 1'b0;
        if (advance) begin
            m_valid_next = busy;
            m_data_next  = beat_data;
            m_last_next  = beat_last;
            if (busy) begin
                if (!phase_done) begin
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    phase_next = after;
                    cnt_next   = '0;
                end
            end
        end
        // Load the next command when idle or as the current one finishes
        if (head_valid && (!busy || (advance && beat_last))) begin
            pop        = 1'b1;
            cur_next   = head_cmd;
            phase_next = pick(head_cmd, FROM_SEP);
            cnt_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg    <= cur_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ dv/tb.sv @@
// Self-checking testbench for the text section cleanup filter.
`timescale 1ns / 100ps

module tb;

    localparam int DASHES     = 21;
    localparam int RAND_ITEMS = 254;
    localparam int CALM_AFTER = 210;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } clean_beat_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       typed;     // expectation written in the row
        logic       one_beat;  // typed row yields a single beat
        logic [7:0] beat;
    } stim_row_t;

    logic       aclk     = 1'b0;
    logic       aresetn  = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // Predictor state
    logic [1:0]  mark_held    = tscf_pkg::HELD_NONE;
    bit          null_pending = 1'b0;
    clean_beat_t step_q[$];
    clean_beat_t clean_q[$];
    clean_beat_t head_beat;

    int  err_cnt    = 0;
    int  stall_left = 0;
    bit  quiet_tail = 1'b0;
    int  rand_sent  = 0;

    stim_row_t dir_rows [26] = '{
        '{8'h41, 1'b0, 1'b1, 1'b1, 8'h41},
        '{8'hFF, 1'b0, 1'b1, 1'b1, 8'hFF},
        '{8'h01, 1'b0, 1'b1, 1'b1, 8'h01},
        '{8'h80, 1'b0, 1'b1, 1'b1, 8'h80},
        '{8'hEF, 1'b0, 1'b1, 1'b0, 8'h00},   // full marker, dropped
        '{8'hBB, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'hBF, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'hEF, 1'b0, 1'b1, 1'b0, 8'h00},   // broken after one byte
        '{8'h41, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'hEF, 1'b0, 1'b1, 1'b0, 8'h00},   // broken after two, restarts
        '{8'hBB, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'hEF, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'hBB, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'hBF, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'hEF, 1'b0, 1'b1, 1'b0, 8'h00},   // null after partial marker
        '{8'h00, 1'b0, 1'b0, 1'b0, 8'h00},
        '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'h42, 1'b0, 1'b0, 1'b0, 8'h00},   // separator plus byte
        '{8'hEF, 1'b0, 1'b1, 1'b0, 8'h00},   // marker cut by section end
        '{8'hBB, 1'b1, 1'b0, 1'b0, 8'h00},
        '{8'hEF, 1'b1, 1'b1, 1'b1, 8'hEF},
        '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00},   // null run reaching the end
        '{8'h00, 1'b1, 1'b1, 1'b0, 8'h00},
        '{8'h43, 1'b0, 1'b1, 1'b1, 8'h43},
        '{8'h00, 1'b0, 1'b1, 1'b0, 8'h00},
        '{8'hEF, 1'b1, 1'b0, 1'b0, 8'h00}
    };

    text_section_cleanup_filter #(
        .SEPARATOR_DASHES(DASHES)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),   // in_byte[7:0]
        .s_tlast (s_tlast),   // section_last
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),   // out_byte[7:0]
        .m_tlast (m_tlast)    // run_last
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic void emit_clean(input logic [7:0] b);
        step_q.push_back('{data: b, last: 1'b0});
    endfunction

    function automatic void flush_marker();
        if (mark_held == tscf_pkg::HELD_EF || mark_held == tscf_pkg::HELD_EFBB) begin
            emit_clean(tscf_pkg::MARK0_BYTE);
            if (mark_held == tscf_pkg::HELD_EFBB)
                emit_clean(tscf_pkg::MARK1_BYTE);
        end
        mark_held = tscf_pkg::HELD_NONE;
    endfunction

    // Advance the predictor by one byte; queue its beats when keep is set.
    function automatic void predict_cleanup(input logic [7:0] b_in, input bit last_in,
                                            input bit keep);
        logic [7:0] b;
        bit         pass_b;
        b      = b_in;
        pass_b = 1'b1;
        step_q = {};
        if (mark_held != tscf_pkg::HELD_NONE && mark_held != tscf_pkg::HELD_EF
            && mark_held != tscf_pkg::HELD_EFBB)
            mark_held = tscf_pkg::HELD_NONE;
        if (b == tscf_pkg::NUL_BYTE) begin
            flush_marker();
            null_pending = 1'b1;
        end else begin
            if (null_pending) begin
                emit_clean(tscf_pkg::NEWLINE);
                for (int i = 0; i < DASHES; i++)
                    emit_clean(tscf_pkg::DASH);
                emit_clean(tscf_pkg::NEWLINE);
                emit_clean(tscf_pkg::NEWLINE);
                null_pending = 1'b0;
            end
            if (mark_held == tscf_pkg::HELD_EF) begin
                if (b == tscf_pkg::MARK1_BYTE) begin
                    mark_held = tscf_pkg::HELD_EFBB;
                    pass_b    = 1'b0;
                end else begin
                    flush_marker();
                end
            end else if (mark_held == tscf_pkg::HELD_EFBB) begin
                if (b == tscf_pkg::MARK2_BYTE) begin
                    mark_held = tscf_pkg::HELD_NONE;
                    pass_b    = 1'b0;
                end else begin
                    flush_marker();
                end
            end
            if (pass_b) begin
                if (b == tscf_pkg::MARK0_BYTE)
                    mark_held = tscf_pkg::HELD_EF;
                else
                    emit_clean(b);
            end
        end
        if (last_in) begin
            flush_marker();
            null_pending = 1'b0;
        end
        if (step_q.size() > 0)
            step_q[step_q.size() - 1].last = 1'b1;
        if (keep)
            foreach (step_q[i]) clean_q.push_back(step_q[i]);
    endfunction

    // Drive one beat, hold it until accepted, then predict.
    task automatic send_byte(input logic [7:0] b, input bit last_in, input bit keep);
        if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge aclk);
        end
        s_tdata  <= b;
        s_tlast  <= last_in;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_cleanup(b, last_in, keep);
    endtask

    // Build one section from well-formed pieces and noise, then send it.
    task automatic send_section();
        logic [7:0] sec[$];
        int         pieces;
        logic [7:0] noise [4];
        noise  = '{tscf_pkg::MARK0_BYTE, tscf_pkg::MARK1_BYTE, tscf_pkg::MARK2_BYTE,
                   tscf_pkg::NUL_BYTE};
        pieces = $urandom_range(1, 6);
        repeat (pieces) begin
            case ($urandom_range(0, 9))
                0, 1, 2: sec.push_back(8'($urandom_range(0, 255)));
                3, 4: begin
                    sec.push_back(tscf_pkg::MARK0_BYTE);
                    sec.push_back(tscf_pkg::MARK1_BYTE);
                    sec.push_back(tscf_pkg::MARK2_BYTE);
                end
                5: begin
                    sec.push_back(tscf_pkg::MARK0_BYTE);
                    if ($urandom_range(0, 1)) sec.push_back(tscf_pkg::MARK1_BYTE);
                    sec.push_back(8'($urandom_range(0, 255)));
                end
                6, 7: repeat ($urandom_range(1, 4)) sec.push_back(tscf_pkg::NUL_BYTE);
                8: begin
                    sec.push_back(tscf_pkg::MARK0_BYTE);
                    if ($urandom_range(0, 1)) sec.push_back(tscf_pkg::MARK1_BYTE);
                    sec.push_back(tscf_pkg::NUL_BYTE);
                end
                default: sec.push_back(noise[$urandom_range(0, 3)]);
            endcase
        end
        foreach (sec[i]) begin
            send_byte(sec[i], i == sec.size() - 1, 1'b1);
            rand_sent++;
            if (rand_sent >= CALM_AFTER) quiet_tail = 1'b1;
        end
    endtask

    // Output backpressure in bursts; no new bursts once the tail starts.
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if (!quiet_tail && $urandom_range(0, 9) == 0) begin
            stall_left <= $urandom_range(0, 12);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (clean_q.size() == 0) begin
                $display("%0t unexpected beat: expected none, got byte %h last %b",
                         $time, m_tdata, m_tlast);
                err_cnt++;
            end else begin
                head_beat = clean_q.pop_front();
                if (m_tdata !== head_beat.data) begin
                    $display("%0t out_byte mismatch: expected %h, got %h",
                             $time, head_beat.data, m_tdata);
                    err_cnt++;
                end
                if (m_tlast !== head_beat.last) begin
                    $display("%0t run_last mismatch: expected %b, got %b",
                             $time, head_beat.last, m_tlast);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        #5000000;
        $display("[text_section_cleanup_filter] ERROR");
        $finish;
    end

    initial begin
        int drain;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].data, dir_rows[i].last, !dir_rows[i].typed);
            if (dir_rows[i].typed && dir_rows[i].one_beat)
                clean_q.push_back('{data: dir_rows[i].beat, last: 1'b1});
        end

        while (rand_sent < RAND_ITEMS)
            send_section();
        s_tvalid <= 1'b0;

        drain = 0;
        while (clean_q.size() > 0 && drain < 100000) begin
            @(posedge aclk);
            drain++;
        end
        repeat (20) @(posedge aclk);
        if (clean_q.size() > 0) begin
            $display("%0t %0d expected beats never arrived, next byte %h last %b",
                     $time, clean_q.size(), clean_q[0].data, clean_q[0].last);
            err_cnt++;
        end

        if (err_cnt == 0)
            $display("[text_section_cleanup_filter] OK");
        else
            $display("[text_section_cleanup_filter] ERROR");
        $finish;
    end

endmodule
